FILE: sv/sem_pkg.sv
`timescale 1ns / 1ps
package sem_pkg;
   localparam int MaxWidth  = 2048;
   localparam int MaxHeight = 4095;
   localparam int ColBits   = $clog2(MaxWidth);
   localparam int RowBits   = 12;
   localparam int DimBits   = 12;
   localparam logic [DimBits-1:0] ResetWidth  = DimBits'(640);
   localparam logic [DimBits-1:0] ResetHeight = DimBits'(480);

   localparam logic [1:0] RegWidth  = 2'd0;
   localparam logic [1:0] RegHeight = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_EMIT
   } state_type;

   // result item before packing
   typedef struct packed {
      logic [23:0]        colour;
      logic [ColBits-1:0] col;
      logic [RowBits-1:0] row;
      logic               interior;
   } result_type;
endpackage

FILE: sv/sem_ram.sv
`timescale 1ns / 1ps
module sem_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/sem_mag.sv
`timescale 1ns / 1ps
// Integer square root of a sum of squares, clamped to 255, one bit a cycle.
module sem_mag
   import sem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] sum,
   output logic        done,
   output logic [7:0]  mag
);
   logic [16:0] sum_ff, sum_in;
   logic [7:0]  res_ff, res_in;
   logic [7:0]  bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [7:0]  trial;
   logic [15:0] trial_sq;

   assign trial    = res_ff | bit_ff;
   assign trial_sq = 16'(trial) * 16'(trial);

   always_comb begin
      sum_in  = sum_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         sum_in  = sum;
         bit_in  = 8'h80;
         busy_in = 1'b1;
         res_in  = (sum >= 17'd65025) ? 8'hff : 8'h00;
         if (sum >= 17'd65025) begin
            bit_in = 8'h00;
         end
      end else if (busy_ff) begin
         if (bit_ff == 8'h00) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (17'(trial_sq) <= sum_ff) begin
               res_in = trial;
            end
            bit_in = bit_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sum_ff <= sum_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign mag  = res_ff;
endmodule

FILE: sv/sobel_edge_magnitude.sv
`timescale 1ns / 1ps
// 3x3 Sobel edge magnitude over a raster-order RGB stream. Each request is one
// pixel; the block tracks its own column and row. Interior pixels come out grey
// at min(255, isqrt(gx^2+gy^2)) of the luma, border pixels in their original
// colour, each tagged with its position; last-row borders are interleaved, so
// one request yields zero to four responses, tlast marking the final one.
// An interior pixel passes through acceptance, a line-store read, registering of
// the sum of squares, a square-root start and the bit-serial square root, then
// its responses; a border pixel skips the square root. No new pixel is taken
// until the last response of the current one is accepted.
// Writing width or height restarts the frame. Line stores hold luma of two
// rows and colour of one; their contents after reset are zero in effect, since
// a read only feeds results once the current frame has written that entry.
module sobel_edge_magnitude
   import sem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // tdata: blue[7:0], green[15:8], red[23:16]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // tdata: out_blue[7:0], out_green[15:8], out_red[23:16], out_col[34:24],
   //        out_row[46:35], zeros[47]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // tuser: is_interior
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   state_type state_ff, state_in;

   logic [DimBits-1:0] width_reg_ff, height_reg_ff;
   logic [ColBits-1:0] col_ff, col_in;
   logic [RowBits-1:0] row_ff, row_in;
   logic [7:0]         win_ff [9];
   logic [23:0]        hold_above_ff, hold_pix_ff;
   logic [23:0]        pix_ff;
   logic [7:0]         luma_ff;
   logic [23:0]        above_ff;
   logic [23:0]        top_ff;
   logic [23:0]        prev_pix_ff;
   result_type         res_ff [4];
   logic [3:0]         res_vld_ff, res_vld_in;
   logic [7:0]         mag_res;
   logic               mag_done, mag_start;
   logic [16:0]        sum_ff;
   logic               sum_vld_ff;
   logic               wait_mag_ff;

   // configuration
   logic cfg_wr;
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel & csr_penable & csr_pwrite;
   always_comb begin
      unique case (csr_paddr[2])
         RegWidth[0]:  csr_prdata = 32'(width_reg_ff);
         default:      csr_prdata = 32'(height_reg_ff);
      endcase
   end
   logic wr_w, wr_h;
   assign wr_w = cfg_wr && (csr_paddr == {RegWidth[0], 2'b00});
   assign wr_h = cfg_wr && (csr_paddr == {RegHeight[0], 2'b00});

   // effective dimensions
   logic [DimBits:0] w_eff, h_eff;
   always_comb begin
      w_eff = (width_reg_ff == '0) ? 13'd1 : 13'(width_reg_ff);
      if (w_eff > 13'(MaxWidth)) w_eff = 13'(MaxWidth);
      h_eff = (height_reg_ff == '0) ? 13'd1 : 13'(height_reg_ff);
      if (h_eff > 13'(MaxHeight)) h_eff = 13'(MaxHeight);
   end

   // luma in fixed point
   logic [24:0] luma_sum;
   assign luma_sum = 25'(req_tdata[23:16]) * 25'd19595
                   + 25'(req_tdata[15:8]) * 25'd38470
                   + 25'(req_tdata[7:0]) * 25'd7471;

   logic accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid & req_tready;

   // line stores
   logic [7:0]  top_q, mid_q;
   logic [23:0] col_q;
   logic        wr_lines;
   assign wr_lines = (state_ff == ST_READ);
   sem_ram #(.Width(8), .Depth(MaxWidth)) u_top (
      .clock(clock), .wr_en(wr_lines), .wr_addr(col_ff), .wr_data(mid_q),
      .rd_addr(col_ff), .rd_data(top_q));
   sem_ram #(.Width(8), .Depth(MaxWidth)) u_mid (
      .clock(clock), .wr_en(wr_lines), .wr_addr(col_ff), .wr_data(luma_ff),
      .rd_addr(col_ff), .rd_data(mid_q));
   sem_ram #(.Width(24), .Depth(MaxWidth)) u_col (
      .clock(clock), .wr_en(wr_lines), .wr_addr(col_ff), .wr_data(pix_ff),
      .rd_addr(col_ff), .rd_data(col_q));

   // gradient from the shifted window
   logic signed [11:0] gx, gy;
   logic [10:0]        ax, ay;
   always_comb begin
      gx = (12'(win_ff[2]) + 12'(2 * win_ff[5]) + 12'(win_ff[8]))
         - (12'(win_ff[0]) + 12'(2 * win_ff[3]) + 12'(win_ff[6]));
      gy = (12'(win_ff[6]) + 12'(2 * win_ff[7]) + 12'(win_ff[8]))
         - (12'(win_ff[0]) + 12'(2 * win_ff[1]) + 12'(win_ff[2]));
      ax = gx[11] ? 11'(-gx) : 11'(gx);
      ay = gy[11] ? 11'(-gy) : 11'(gy);
   end
   logic [21:0] ssq;
   assign ssq = 22'(ax) * 22'(ax) + 22'(ay) * 22'(ay);

   sem_mag u_mag (.clock(clock), .reset(reset), .start(mag_start),
      .sum(sum_ff), .done(mag_done), .mag(mag_res));

   // position tests for the current pixel
   logic row_ge1, col_ge1, is_int, col_last, row_last;
   assign row_ge1  = row_ff != '0;
   assign col_ge1  = col_ff != '0;
   assign is_int   = (row_ff >= 12'd2) && (col_ff >= 11'd2);
   assign col_last = 13'(col_ff) == w_eff - 13'd1;
   assign row_last = 13'(row_ff) == h_eff - 13'd1;

   // response slot picking lowest pending
   logic [1:0] sel;
   always_comb begin
      sel = 2'd3;
      for (int i = 3; i >= 0; i--) if (res_vld_ff[i]) sel = 2'(i);
   end
   logic more;
   assign more = (res_vld_ff & ~(4'b1 << sel)) != '0;

   assign rsp_tvalid = (state_ff == ST_EMIT) && (res_vld_ff != '0);
   assign rsp_tdata  = {1'b0, res_ff[sel].row, res_ff[sel].col, res_ff[sel].colour};
   assign rsp_tuser  = res_ff[sel].interior;
   assign rsp_tlast  = !more;

   // square root starts once the sum of the new window is registered
   assign mag_start = (state_ff == ST_CALC) && sum_vld_ff && !wait_mag_ff && is_int
                    && row_ge1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = ST_CALC;
         ST_CALC: begin
            if (!is_int || wait_mag_ff && mag_done) begin
               state_in = (res_vld_in != '0) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: if (rsp_tready && !more) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // result slots and counters
   always_comb begin
      res_vld_in = res_vld_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (state_ff == ST_CALC) begin
         res_vld_in = {row_last && col_last, row_last && col_ge1,
                       row_ge1 && col_last, row_ge1 && col_ge1};
      end else if (state_ff == ST_EMIT && rsp_tready) begin
         res_vld_in = res_vld_ff & ~(4'b1 << sel);
      end
      if (state_ff == ST_CALC) begin
         if (13'(col_ff) + 13'd1 >= w_eff) begin
            col_in = '0;
            row_in = (13'(row_ff) + 13'd1 >= h_eff) ? '0 : row_ff + 12'd1;
         end else begin
            col_in = col_ff + 11'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         width_reg_ff  <= ResetWidth;
         height_reg_ff <= ResetHeight;
         col_ff        <= '0;
         row_ff        <= '0;
         res_vld_ff    <= '0;
         wait_mag_ff   <= 1'b0;
         sum_vld_ff    <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
         hold_above_ff <= '0;
         hold_pix_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         res_vld_ff <= res_vld_in;
         if (wr_w) width_reg_ff <= csr_pwdata[DimBits-1:0];
         if (wr_h) height_reg_ff <= csr_pwdata[DimBits-1:0];
         if (wr_w || wr_h) begin
            col_ff <= '0;
            row_ff <= '0;
         end
         if (state_ff == ST_CALC && state_in != ST_CALC) begin
            // advance position once the pixel's results are fixed
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (state_ff == ST_READ) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i*3]   <= win_ff[i*3+1];
               win_ff[i*3+1] <= win_ff[i*3+2];
            end
            win_ff[2]     <= top_q;
            win_ff[5]     <= mid_q;
            win_ff[8]     <= luma_ff;
            hold_above_ff <= col_q;
            hold_pix_ff   <= pix_ff;
            wait_mag_ff   <= 1'b0;
            sum_vld_ff    <= 1'b0;
         end
         if (state_ff == ST_CALC) sum_vld_ff <= 1'b1;
         if (mag_start) wait_mag_ff <= 1'b1;
      end
      if (accept) begin
         pix_ff  <= req_tdata;
         luma_ff <= luma_sum[23:16];
      end
      if (state_ff == ST_READ) begin
         above_ff    <= col_q;
         top_ff      <= hold_above_ff;
         prev_pix_ff <= hold_pix_ff;
      end
      // anything at or above 255^2 gives the same clamped magnitude
      sum_ff <= (ssq >= 22'd65025) ? 17'd65025 : 17'(ssq);
      if (state_ff == ST_CALC) begin
         res_ff[0].colour   <= is_int ? {3{mag_res}} : top_ff;
         res_ff[0].col      <= col_ff - 11'd1;
         res_ff[0].row      <= row_ff - 12'd1;
         res_ff[0].interior <= is_int;
         res_ff[1].colour   <= above_ff;
         res_ff[1].col      <= 11'(w_eff - 13'd1);
         res_ff[1].row      <= row_ff - 12'd1;
         res_ff[1].interior <= 1'b0;
         res_ff[2].colour   <= prev_pix_ff;
         res_ff[2].col      <= col_ff - 11'd1;
         res_ff[2].row      <= 12'(h_eff - 13'd1);
         res_ff[2].interior <= 1'b0;
         res_ff[3].colour   <= pix_ff;
         res_ff[3].col      <= 11'(w_eff - 13'd1);
         res_ff[3].row      <= 12'(h_eff - 13'd1);
         res_ff[3].interior <= 1'b0;
      end
   end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import sem_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sobel_edge_magnitude dut (.*);

   always #5 clock = ~clock;

   // expected response: tdata, tuser, tlast
   typedef struct packed {
      logic [47:0] data;
      logic        interior;
      logic        last;
   } pixel_out_type;

   pixel_out_type pending_pixels[$];
   int         mismatches = 0;
   int         cycles = 0;
   bit         stall_mode = 0;

   // shadow of the block
   logic [11:0] width_reg = ResetWidth;
   logic [11:0] height_reg = ResetHeight;
   logic [7:0]  luma_mem[2*MaxWidth];
   logic [23:0] colour_mem[MaxWidth];
   logic [7:0]  win[9];
   logic [23:0] hold_above, hold_prev;
   int unsigned col_pos = 0, row_pos = 0;

   initial begin
      foreach (luma_mem[i]) luma_mem[i] = '0;
      foreach (colour_mem[i]) colour_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      hold_above = '0;
      hold_prev = '0;
   end

   function automatic logic [7:0] isqrt_sat(int unsigned s);
      int unsigned res, t;
      res = 0;
      if (s >= 255 * 255) return 8'd255;
      for (int b = 7; b >= 0; b--) begin
         t = res + (1 << b);
         if (t * t <= s) res = t;
      end
      return res[7:0];
   endfunction

   function automatic void push_pixel(logic [23:0] colour, int unsigned col,
                                      int unsigned row, logic interior);
      pixel_out_type p;
      p.data = {1'b0, row[11:0], col[10:0], colour};
      p.interior = interior;
      p.last = 1'b0;
      pending_pixels.push_back(p);
   endfunction

   // predict the responses caused by one pixel
   function automatic void predict_pixel(logic [23:0] pix);
      int unsigned w, h, c, r, luma, top, mid, ax, ay, n0;
      int gx, gy;
      logic [23:0] above, prev_above, prev_pix;
      logic [7:0] m;
      w = (width_reg == 0) ? 1 : (width_reg > MaxWidth ? MaxWidth : width_reg);
      h = (height_reg == 0) ? 1 : (height_reg > MaxHeight ? MaxHeight : height_reg);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      luma = (19595 * pix[23:16] + 38470 * pix[15:8] + 7471 * pix[7:0]) >> 16;
      top = luma_mem[MaxWidth + c];
      mid = luma_mem[c];
      luma_mem[MaxWidth + c] = mid[7:0];
      luma_mem[c] = luma[7:0];
      for (int i = 0; i < 3; i++) begin
         win[i*3] = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = top[7:0];
      win[5] = mid[7:0];
      win[8] = luma[7:0];
      above = colour_mem[c];
      colour_mem[c] = pix;
      prev_above = hold_above;
      prev_pix = hold_prev;
      hold_above = above;
      hold_prev = pix;
      n0 = pending_pixels.size();
      if (r >= 1 && c >= 1) begin
         if (r >= 2 && c >= 2) begin
            gx = (win[2] + 2 * win[5] + win[8]) - (win[0] + 2 * win[3] + win[6]);
            gy = (win[6] + 2 * win[7] + win[8]) - (win[0] + 2 * win[1] + win[2]);
            ax = gx < 0 ? -gx : gx;
            ay = gy < 0 ? -gy : gy;
            m = isqrt_sat(ax * ax + ay * ay);
            push_pixel({m, m, m}, c - 1, r - 1, 1'b1);
         end else begin
            push_pixel(prev_above, c - 1, r - 1, 1'b0);
         end
      end
      if (r >= 1 && c == w - 1) push_pixel(above, w - 1, r - 1, 1'b0);
      if (r == h - 1 && c >= 1) push_pixel(prev_pix, c - 1, h - 1, 1'b0);
      if (r == h - 1 && c == w - 1) push_pixel(pix, w - 1, h - 1, 1'b0);
      if (pending_pixels.size() > n0)
         pending_pixels[pending_pixels.size() - 1].last = 1'b1;
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endfunction

   // response checker
   always @(posedge clock) begin
      pixel_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response data=%h user=%b last=%b",
                        rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata !== want.data || rsp_tuser !== want.interior
                || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: exp data=%h user=%b last=%b, got %h %b %b",
                           want.data, want.interior, want.last,
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      cycles++;
      if (stall_mode) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= 1'b1;
      if (cycles > 2000000) begin
         $display("[sobel_edge_magnitude] ERROR");
         $finish;
      end
   end

   task automatic send_pixel(logic [23:0] pix);
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_pixel(pix);
      // burst gaps
      if (stall_mode && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == 3'(4 * RegWidth)) width_reg = value[11:0];
      else height_reg = value[11:0];
      col_pos = 0;
      row_pos = 0;
   endtask

   task automatic set_frame(int unsigned w, int unsigned h);
      write_reg(3'(4 * RegWidth), w);
      write_reg(3'(4 * RegHeight), h);
   endtask

   function automatic logic [23:0] rand_pixel();
      return 24'($urandom);
   endfunction

   // directed: extreme colours, strong edges on a 4x4 frame
   task automatic test_directed_edges();
      set_frame(4, 4);
      for (int i = 0; i < 16; i++)
         send_pixel(((i % 4) < 2) ? 24'h000000 : 24'hFFFFFF);
      send_pixel(24'hFF0000);
      send_pixel(24'h00FF00);
      send_pixel(24'h0000FF);
      send_pixel(24'hA55A3C);
      drain();
   endtask

   // tiny frames: width 1, height 1, zero values, oversize values
   task automatic test_tiny_frames();
      set_frame(1, 3);
      repeat (6) send_pixel(rand_pixel());
      drain();
      set_frame(5, 1);
      repeat (7) send_pixel(rand_pixel());
      drain();
      set_frame(0, 0);
      repeat (3) send_pixel(rand_pixel());
      drain();
      set_frame(4095, 4095);
      repeat (5) send_pixel(rand_pixel());
      drain();
   endtask

   // random frames, mostly with random stalls
   task automatic test_random_frames();
      int unsigned w, h, n;
      stall_mode = 1;
      for (int f = 0; f < 8; f++) begin
         w = $urandom_range(1, 7);
         h = $urandom_range(1, 5);
         set_frame(w, h);
         n = w * h * $urandom_range(1, 2) + $urandom_range(0, 3);
         for (int i = 0; i < n; i++) send_pixel(rand_pixel());
         drain();
         stall_mode = (f % 3 != 2);
      end
      set_frame(2048, 3);
      repeat (20) send_pixel(rand_pixel());
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_tiny_frames();
      test_random_frames();
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("[sobel_edge_magnitude] OK");
      end else begin
         $display("[sobel_edge_magnitude] ERROR");
      end
      $finish;
   end
endmodule
